FILE: rtl/dsfp_pkg.sv
// ----------------------------------------------------------------------------
// dsfp_pkg: shared types and constants of the display settings frame parser
// Frame geometry, register indexes, reset values and the command format that
// passes from the byte classifier to the frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package dsfp_pkg;

  // Frame buffer geometry.
  localparam int FRAME_BYTES = 13;
  localparam int SLOT_W      = $clog2(FRAME_BYTES);
  localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(FRAME_BYTES - 1);
  localparam logic [SLOT_W-1:0] FIRST_SLOT = '0;
  // Slot that carries the reported check and stays out of the XOR.
  localparam logic [SLOT_W-1:0] CHECK_SLOT = SLOT_W'(5);

  // Configuration registers.
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_DELIMITER = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_CHECK_OFFSET    = CFG_INDEX_W'(1);
  localparam logic [7:0] DELIMITER_RESET = 8'd14;
  localparam logic [7:0] OFFSET_RESET    = 8'd12;

  // Decode constants.
  localparam logic [2:0] WALK_CODE      = 3'd6;
  localparam logic [5:0] MAX_SPEED_BASE = 6'd10;

  // Command queue between classifier and decoder.
  localparam int CMD_DEPTH = 2;
  localparam int CMD_PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  // One command: either store a byte into a slot, or close the frame.
  typedef struct packed {
    logic              is_close;
    logic [SLOT_W-1:0] slot;
    logic [7:0]        data;
  } cmd_t;

  // Queue fill status.
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  // Decoder activity, seen by the top level.
  typedef struct packed {
    logic idle;
    logic sweeping;
  } back_status_t;

endpackage

`default_nettype wire

FILE: rtl/dsfp_front.sv
// ----------------------------------------------------------------------------
// dsfp_front: received byte classifier
// Tracks frame framing and the write index, and turns each received byte
// into a store command, a close command, or nothing.
// ----------------------------------------------------------------------------
`default_nettype none

module dsfp_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [7:0]            in_rx_byte,
  input  wire logic [7:0]            frame_delimiter,
  input  wire dsfp_pkg::fifo_status_t fifo_st,
  output logic                       cmd_push,
  output dsfp_pkg::cmd_t             cmd
);

  logic                        in_frame_r, in_frame_nxt;
  logic [dsfp_pkg::SLOT_W-1:0] wr_idx_r, wr_idx_nxt;
  logic                        accept;
  logic                        is_delim;

  // A byte is taken only when the queue can hold whatever it produces.
  assign in_ready = !fifo_st.full;
  assign accept   = in_valid && in_ready;
  assign is_delim = (in_rx_byte == frame_delimiter);

  // Command fields follow the current byte and index.
  assign cmd.is_close = is_delim;
  assign cmd.slot     = wr_idx_r;
  assign cmd.data     = in_rx_byte;
  assign cmd_push     = accept && in_frame_r;

  // Framing state and the saturating write index.
  always_comb begin
    in_frame_nxt = in_frame_r;
    wr_idx_nxt   = wr_idx_r;
    if (accept) begin
      if (!in_frame_r) begin
        if (is_delim) begin
          in_frame_nxt = 1'b1;
        end
      end else if (is_delim) begin
        in_frame_nxt = 1'b0;
        wr_idx_nxt   = dsfp_pkg::FIRST_SLOT;
      end else if (wr_idx_r != dsfp_pkg::LAST_SLOT) begin
        wr_idx_nxt = wr_idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      wr_idx_r   <= dsfp_pkg::FIRST_SLOT;
    end else begin
      in_frame_r <= in_frame_nxt;
      wr_idx_r   <= wr_idx_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/dsfp_cmd_fifo.sv
// ----------------------------------------------------------------------------
// dsfp_cmd_fifo: command queue
// A short first-in first-out queue that decouples the classifier from the
// decoder, so each side stalls on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module dsfp_cmd_fifo (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire dsfp_pkg::cmd_t        push_cmd,
  input  wire logic                  pop,
  output dsfp_pkg::cmd_t             head_cmd,
  output dsfp_pkg::fifo_status_t     status
);

  localparam logic [dsfp_pkg::CMD_PTR_W-1:0] PTR_LAST =
    dsfp_pkg::CMD_PTR_W'(dsfp_pkg::CMD_DEPTH - 1);
  localparam logic [dsfp_pkg::CMD_CNT_W-1:0] CNT_FULL =
    dsfp_pkg::CMD_CNT_W'(dsfp_pkg::CMD_DEPTH);

  dsfp_pkg::cmd_t                 entry_r [dsfp_pkg::CMD_DEPTH];
  logic [dsfp_pkg::CMD_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [dsfp_pkg::CMD_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [dsfp_pkg::CMD_CNT_W-1:0] count_r, count_nxt;
  logic                           do_push, do_pop;

  assign status.full  = (count_r == CNT_FULL);
  assign status.empty = (count_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head_cmd     = entry_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/dsfp_back.sv
// ----------------------------------------------------------------------------
// dsfp_back: frame buffer and decoder
// Executes queued commands: stores bytes into the frame buffer, and on a
// close sweeps the buffer one byte per cycle to build the XOR check, then
// decodes the settings into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dsfp_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cmd_valid,
  input  wire dsfp_pkg::cmd_t        cmd,
  output logic                       cmd_pop,
  input  wire logic [7:0]            check_offset,
  output dsfp_pkg::back_status_t     status,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [2:0]                 out_assist_level,
  output logic                       out_walk_assist,
  output logic                       out_light_on,
  output logic                       out_cruise_request,
  output logic [5:0]                 out_max_speed,
  output logic [4:0]                 out_wheel_size_code,
  output logic [7:0]                 out_p1_value,
  output logic [4:0]                 out_p_flag_bits,
  output logic [7:0]                 out_p5_value,
  output logic [24:0]                out_c_fields,
  output logic [7:0]                 out_computed_check,
  output logic [7:0]                 out_reported_check
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SWEEP = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;

  logic [1:0]                  state_r, state_nxt;
  logic [dsfp_pkg::SLOT_W-1:0] sweep_idx_r, sweep_idx_nxt;
  logic [7:0]                  xor_acc_r, xor_acc_nxt;
  logic [2:0]                  held_level_r, held_level_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [7:0]                  buf_r [dsfp_pkg::FRAME_BYTES];
  logic                        store_en;
  logic                        load_out;

  // Decoded fields.
  logic [7:0]  b0, b1, b2, b3, b4, b5, b6, b7, b8, b9, b10;
  logic        walk;
  logic [2:0]  level_dec;
  logic [5:0]  speed_dec;
  logic [24:0] c_dec;

  assign cmd_pop         = (state_r == ST_IDLE) && cmd_valid;
  assign store_en        = cmd_pop && !cmd.is_close;
  assign load_out        = (state_r == ST_EMIT) && (!out_valid_r || out_ready);
  assign status.idle     = (state_r == ST_IDLE);
  assign status.sweeping = (state_r == ST_SWEEP);
  assign out_valid       = out_valid_r;

  // Sequencer: dispatch, XOR sweep, then wait for the output register.
  always_comb begin
    state_nxt     = state_r;
    sweep_idx_nxt = sweep_idx_r;
    xor_acc_nxt   = xor_acc_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd_pop && cmd.is_close) begin
          state_nxt     = ST_SWEEP;
          sweep_idx_nxt = dsfp_pkg::FIRST_SLOT;
          xor_acc_nxt   = '0;
        end
      end
      ST_SWEEP: begin
        if (sweep_idx_r != dsfp_pkg::CHECK_SLOT) begin
          xor_acc_nxt = xor_acc_r ^ buf_r[sweep_idx_r];
        end
        if (sweep_idx_r == dsfp_pkg::LAST_SLOT) begin
          state_nxt = ST_EMIT;
        end else begin
          sweep_idx_nxt = sweep_idx_r + 1'b1;
        end
      end
      ST_EMIT: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output valid and the held assist level.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    held_level_nxt = held_level_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt  = 1'b1;
      held_level_nxt = level_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      sweep_idx_r  <= dsfp_pkg::FIRST_SLOT;
      xor_acc_r    <= '0;
      held_level_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sweep_idx_r  <= sweep_idx_nxt;
      xor_acc_r    <= xor_acc_nxt;
      held_level_r <= held_level_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Frame buffer; it reads as zeros after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < dsfp_pkg::FRAME_BYTES; i++) begin
        buf_r[i] <= '0;
      end
    end else if (store_en) begin
      buf_r[cmd.slot] <= cmd.data;
    end
  end

  // Field decode from fixed buffer slots.
  assign b0  = buf_r[0];
  assign b1  = buf_r[1];
  assign b2  = buf_r[2];
  assign b3  = buf_r[3];
  assign b4  = buf_r[4];
  assign b5  = buf_r[5];
  assign b6  = buf_r[6];
  assign b7  = buf_r[7];
  assign b8  = buf_r[8];
  assign b9  = buf_r[9];
  assign b10 = buf_r[10];

  // In walk assist the level repeats the last held one.
  assign walk      = (b1[2:0] == dsfp_pkg::WALK_CODE);
  assign level_dec = walk ? held_level_r : b1[2:0];
  assign speed_dec = (dsfp_pkg::MAX_SPEED_BASE + {1'b0, b2[7:3]}) | {b4[5], 5'b0};
  // C14, C13, C12, C5, C4, C2 (masked 0x37), C1 from high bits down.
  assign c_dec = {b7[6:5], b10[4:2], b9[3:0], b7[3:0], b8[7:5],
                  b6[5:4], 1'b0, b6[2:0], b6[5:3]};

  // Result register; payload needs no reset.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_assist_level    <= level_dec;
      out_walk_assist     <= walk;
      out_light_on        <= b1[7];
      out_cruise_request  <= b8[4];
      out_max_speed       <= speed_dec;
      out_wheel_size_code <= {b2[2:0], b4[7:6]};
      out_p1_value        <= b3;
      out_p_flag_bits     <= b4[4:0];
      out_p5_value        <= b0;
      out_c_fields        <= c_dec;
      out_computed_check  <= xor_acc_r - check_offset;
      out_reported_check  <= b5;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/display_settings_frame_parser_top.sv
// ----------------------------------------------------------------------------
// display_settings_frame_parser_top: display link settings frame parser
// Frames received bytes between delimiters and decodes the settings frame.
// Flow: a closing delimiter yields its result after queue dispatch, the XOR
//   sweep of the frame buffer and the output load.
// Throughput: data bytes are taken one per cycle while the queue is not full;
//   a closing delimiter holds the decoder for the one-byte-per-cycle sweep.
// Reset: synchronous active-low rst_n clears framing, queue, buffer (to zero),
//   held assist level and the registers to their defaults (14 and 12).
// ----------------------------------------------------------------------------
`default_nettype none

module display_settings_frame_parser_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [7:0]                        in_rx_byte,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [dsfp_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [7:0]                        cfg_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [2:0]                             out_assist_level,
  output logic                                   out_walk_assist,
  output logic                                   out_light_on,
  output logic                                   out_cruise_request,
  output logic [5:0]                             out_max_speed,
  output logic [4:0]                             out_wheel_size_code,
  output logic [7:0]                             out_p1_value,
  output logic [4:0]                             out_p_flag_bits,
  output logic [7:0]                             out_p5_value,
  output logic [24:0]                            out_c_fields,
  output logic [7:0]                             out_computed_check,
  output logic [7:0]                             out_reported_check
);

  logic [7:0]             delim_r, delim_nxt;
  logic [7:0]             offset_r, offset_nxt;
  logic                   cfg_wr;
  logic                   cmd_push;
  logic                   cmd_pop;
  dsfp_pkg::cmd_t         push_cmd;
  dsfp_pkg::cmd_t         head_cmd;
  dsfp_pkg::fifo_status_t fifo_st;
  dsfp_pkg::back_status_t back_st;

  // Configuration registers; writes to unknown indexes are dropped.
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_comb begin
    delim_nxt  = delim_r;
    offset_nxt = offset_r;
    if (cfg_wr) begin
      case (cfg_index)
        dsfp_pkg::REG_FRAME_DELIMITER: delim_nxt  = cfg_data;
        dsfp_pkg::REG_CHECK_OFFSET:    offset_nxt = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r  <= dsfp_pkg::DELIMITER_RESET;
      offset_r <= dsfp_pkg::OFFSET_RESET;
    end else begin
      delim_r  <= delim_nxt;
      offset_r <= offset_nxt;
    end
  end

  // Byte classifier.
  dsfp_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .frame_delimiter (delim_r),
    .fifo_st         (fifo_st),
    .cmd_push        (cmd_push),
    .cmd             (push_cmd)
  );

  // Command queue.
  dsfp_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_cmd (push_cmd),
    .pop      (cmd_pop),
    .head_cmd (head_cmd),
    .status   (fifo_st)
  );

  // Frame buffer and decoder.
  dsfp_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd_valid           (!fifo_st.empty),
    .cmd                 (head_cmd),
    .cmd_pop             (cmd_pop),
    .check_offset        (offset_r),
    .status              (back_st),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_assist_level    (out_assist_level),
    .out_walk_assist     (out_walk_assist),
    .out_light_on        (out_light_on),
    .out_cruise_request  (out_cruise_request),
    .out_max_speed       (out_max_speed),
    .out_wheel_size_code (out_wheel_size_code),
    .out_p1_value        (out_p1_value),
    .out_p_flag_bits     (out_p_flag_bits),
    .out_p5_value        (out_p5_value),
    .out_c_fields        (out_c_fields),
    .out_computed_check  (out_computed_check),
    .out_reported_check  (out_reported_check)
  );

  // The queue can never report full and empty together.
  a_fifo_status: assert property (@(posedge clk) disable iff (!rst_n)
    !(fifo_st.full && fifo_st.empty))
    else $error("command queue reports full and empty at once");

  // Store commands never address past the last buffer slot.
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_push && !push_cmd.is_close) |-> (push_cmd.slot <= dsfp_pkg::LAST_SLOT))
    else $error("store command beyond the frame buffer");

  // The decoder takes a command only while idle, never mid-sweep.
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> (back_st.idle && !back_st.sweeping))
    else $error("command taken while the decoder is busy");

  // A finished sweep is followed by the emit step, not a new dispatch.
  a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(back_st.sweeping) |-> !back_st.idle)
    else $error("sweep ended without an output load step");

endmodule

`default_nettype wire
